[rtl/bbr_congestion_window_update_assert.svh]
// assertion macros for the congestion window block
`ifndef BBR_CONGESTION_WINDOW_UPDATE_ASSERT_SVH
`define BBR_CONGESTION_WINDOW_UPDATE_ASSERT_SVH

// same-cycle implication
`define BBR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define BBR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/bbr_cwu_pkg.sv]
`timescale 1ns / 1ps
package bbr_cwu_pkg;

	localparam int IN_W  = 216;
	localparam int OUT_W = 88;

	localparam int GAIN_SHIFT = 8;
	localparam int RATE_SHIFT = 3;

	localparam logic [63:0] LOW_RATE    = 64'd9600000;
	localparam logic [63:0] HIGH_RATE   = 64'd192000000;
	localparam logic [63:0] QUANTUM_CAP = 64'd65536;
	localparam logic [19:0] US_PER_SEC  = 20'd1000000;
	localparam logic [19:0] MS_PER_SEC  = 20'd1000;
	localparam logic [63:0] U32_ALL     = 64'hFFFF_FFFF;

	localparam logic [15:0] WINDOW_GAIN_RST = 16'd512;
	localparam logic [15:0] PACING_GAIN_RST = 16'd256;
	localparam logic [31:0] INIT_WINDOW_RST = 32'd12000;

	localparam logic [1:0] REG_WINDOW_GAIN  = 2'd0;
	localparam logic [1:0] REG_PACING_GAIN  = 2'd1;
	localparam logic [1:0] REG_INIT_WINDOW  = 2'd2;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_RATE_LO,
		OP_RATE_HI,
		OP_WHOLE_MUL,
		OP_FRAC_MUL,
		OP_BDP_MUL,
		OP_INIT_MUL,
		OP_FINISH
	} op_t;

	typedef enum logic [1:0] {
		DIV_QUANTUM,
		DIV_BDP,
		DIV_FRAC
	} div_sel_t;

	typedef struct packed {
		op_t      op;
		logic     div_start;
		div_sel_t div_sel;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic out_free;
	} stat_t;

	function automatic logic [31:0] sat32(input logic [63:0] v);
		return (v > U32_ALL) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

[rtl/bbr_cwu_div.sv]
`timescale 1ns / 1ps
module bbr_cwu_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic        ms,
	output logic        busy,
	output logic        done,
	output logic [63:0] quotient,
	output logic [19:0] remainder
);
	import bbr_cwu_pkg::*;

	// 1000 = 125 * 8 and 1000000 = 15625 * 64: shift off the power of two, multiply
	// by a 32-bit reciprocal of the odd part, then correct the estimate by up to two
	localparam logic [31:0] RCP_MS = 32'd2199023255;
	localparam logic [31:0] RCP_US = 32'd2251799813;
	localparam logic [13:0] ODD_MS = 14'(MS_PER_SEC >> 3);
	localparam logic [13:0] ODD_US = 14'(US_PER_SEC >> 6);

	logic        busy_q, done_q, ms_q;
	logic [2:0]  cnt_q;
	logic [63:0] x_q;
	logic [45:0] y;
	logic [31:0] rcp;
	logic [13:0] odd;
	logic [63:0] plo_q;
	logic [45:0] phi_q;
	logic [77:0] acc;
	logic [31:0] qe_q;
	logic [45:0] qd_q;
	logic [46:0] r0;
	logic [15:0] r1;
	logic [31:0] q1;
	logic [19:0] rem_n;
	logic [63:0] quo_q;
	logic [19:0] rem_q;

	always_comb begin
		y   = ms_q ? 46'(x_q >> 3) : 46'(x_q >> 6);
		rcp = ms_q ? RCP_MS : RCP_US;
		odd = ms_q ? ODD_MS : ODD_US;
		acc = {phi_q, 32'd0} + 78'(plo_q);
		r0  = 47'(y) - 47'(qd_q);
		// the estimate is low by at most two
		if (r0[15:0] >= 16'({odd, 1'b0})) begin
			q1 = qe_q + 32'd2;
			r1 = r0[15:0] - 16'({odd, 1'b0});
		end else if (r0[15:0] >= 16'(odd)) begin
			q1 = qe_q + 32'd1;
			r1 = r0[15:0] - 16'(odd);
		end else begin
			q1 = qe_q;
			r1 = r0[15:0];
		end
		rem_n = ms_q ? 20'({r1, x_q[2:0]}) : 20'({r1, x_q[5:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q  <= dividend;
			ms_q <= ms;
		end else if (busy_q) begin
			case (cnt_q)
				3'd1: plo_q <= 64'(y[31:0]) * 64'(rcp);
				3'd2: phi_q <= 46'(y[45:32]) * 46'(rcp);
				3'd3: qe_q  <= ms_q ? 32'(acc >> 38) : 32'(acc >> 45);
				3'd4: qd_q  <= 46'(qe_q) * 46'(odd);
				3'd5: begin
					quo_q <= 64'(q1);
					rem_q <= rem_n;
				end
				default: ;
			endcase
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

[rtl/bbr_cwu_dp.sv]
`timescale 1ns / 1ps
module bbr_cwu_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bbr_cwu_pkg::cmd_t        cmd,
	output bbr_cwu_pkg::stat_t       stat,
	input  logic [bbr_cwu_pkg::IN_W-1:0]  in_data,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_idx,
	input  logic [31:0]              cfg_wdata,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [bbr_cwu_pkg::OUT_W-1:0] out_data
);
	import bbr_cwu_pkg::*;

	localparam logic [63:0] QDIV_MAX = (QUANTUM_CAP + 64'd1) * 64'(MS_PER_SEC);

	logic [15:0] wg_q, pg_q;
	logic [31:0] iw_q;
	logic [31:0] win_q;
	logic [16:0] quant_q;

	logic [47:0] bw_q, tot_q;
	logic [15:0] pl_q;
	logic [31:0] ack_q, rtt_q, ht_q;
	logic        rttv_q, found_q, htv_q;

	logic [63:0] prod_q, rate_q, p1_q;
	logic [25:0] whole_q;
	logic [19:0] frac_q;
	logic [31:0] q3_q;
	logic [39:0] t1_q, t0_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	div_sel_t    div_sel_q;
	logic [63:0] div_dividend, div_quo, rate_ms;
	logic        div_ms;
	logic [19:0] div_rem;
	logic        div_busy, div_done;

	logic        ov_q;
	logic [31:0] ocw_q, otw_q;
	logic [16:0] osq_q;
	logic        out_free;

	logic [55:0] rate_r;
	logic [16:0] tier;
	logic [63:0] bdp_sum;
	logic [31:0] bdp;
	logic [40:0] alt;
	logic [31:0] base, tgt, nw;
	logic [32:0] grown;
	logic [17:0] floor_w;

	bbr_cwu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.ms        (div_ms),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		case (cmd.op)
			OP_RATE_LO: begin
				mul_a = bw_q[31:0];
				mul_b = {16'd0, pg_q};
			end
			OP_RATE_HI: begin
				mul_a = {16'd0, bw_q[47:32]};
				mul_b = {16'd0, pg_q};
			end
			OP_WHOLE_MUL: begin
				mul_a = {6'd0, whole_q};
				mul_b = rtt_q;
			end
			OP_FRAC_MUL: begin
				mul_a = {12'd0, frac_q};
				mul_b = rtt_q;
			end
			OP_BDP_MUL: begin
				mul_a = bdp;
				mul_b = {16'd0, wg_q};
			end
			OP_INIT_MUL: begin
				mul_a = iw_q;
				mul_b = {16'd0, wg_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 64'(mul_a) * 64'(mul_b);

	always_comb begin
		rate_ms = rate_q >> (GAIN_SHIFT + RATE_SHIFT);
		case (cmd.div_sel)
			DIV_QUANTUM: begin
				// past the cap the quotient only has to exceed it
				div_dividend = (rate_ms > QDIV_MAX) ? QDIV_MAX : rate_ms;
				div_ms       = 1'b1;
			end
			DIV_BDP: begin
				div_dividend = 64'(bw_q >> RATE_SHIFT);
				div_ms       = 1'b0;
			end
			default: begin
				div_dividend = prod_q;
				div_ms       = 1'b0;
			end
		endcase
	end

	// quantum tiers from the pacing rate
	always_comb begin
		rate_r = rate_q[63:GAIN_SHIFT];
		if (64'(rate_r) < LOW_RATE)
			tier = 17'(pl_q);
		else if (64'(rate_r) < HIGH_RATE)
			tier = {pl_q, 1'b0};
		else if (div_quo > QUANTUM_CAP)
			tier = 17'(QUANTUM_CAP);
		else
			tier = div_quo[16:0];
	end

	always_comb begin
		bdp_sum = p1_q + 64'(q3_q);
		bdp     = (p1_q > U32_ALL) ? 32'hFFFF_FFFF : sat32(bdp_sum);
	end

	// target, window growth and the four-payload floor
	always_comb begin
		alt = 41'(t1_q) + 41'({quant_q, 1'b0}) + 41'(quant_q);
		if (bw_q == '0 || !rttv_q)
			base = sat32(64'(t0_q));
		else
			base = sat32(64'(alt));
		if (found_q && htv_q)
			tgt = sat32(64'(base) + 64'(ht_q));
		else
			tgt = base;
		grown = 33'(win_q) + 33'(ack_q);
		if (found_q)
			nw = (grown < 33'(tgt)) ? grown[31:0] : tgt;
		else if (win_q < tgt || tot_q < 48'(iw_q))
			nw = sat32(64'(grown));
		else
			nw = win_q;
		floor_w = {pl_q, 2'b00};
		if (32'(floor_w) > nw)
			nw = 32'(floor_w);
	end

	assign out_free = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wg_q    <= WINDOW_GAIN_RST;
			pg_q    <= PACING_GAIN_RST;
			iw_q    <= INIT_WINDOW_RST;
			win_q   <= INIT_WINDOW_RST;
			quant_q <= '0;
			ov_q    <= 1'b0;
			div_sel_q <= DIV_QUANTUM;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_WINDOW_GAIN: wg_q <= cfg_wdata[15:0];
					REG_PACING_GAIN: pg_q <= cfg_wdata[15:0];
					REG_INIT_WINDOW: iw_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.div_start)
				div_sel_q <= cmd.div_sel;
			if (div_done && div_sel_q == DIV_QUANTUM)
				quant_q <= tier;
			if (cmd.op == OP_FINISH && out_free) begin
				win_q <= nw;
				ov_q  <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				bw_q    <= in_data[47:0];
				pl_q    <= in_data[63:48];
				tot_q   <= in_data[111:64];
				ack_q   <= in_data[143:112];
				rtt_q   <= in_data[175:144];
				rttv_q  <= in_data[176];
				found_q <= in_data[177];
				ht_q    <= in_data[209:178];
				htv_q   <= in_data[210];
			end
			OP_RATE_LO:   prod_q <= mul_p;
			OP_RATE_HI:   rate_q <= prod_q + {mul_p[31:0], 32'd0};
			OP_WHOLE_MUL: p1_q   <= mul_p;
			OP_FRAC_MUL:  prod_q <= mul_p;
			OP_BDP_MUL:   t1_q   <= mul_p[47:GAIN_SHIFT];
			OP_INIT_MUL:  t0_q   <= mul_p[47:GAIN_SHIFT];
			OP_FINISH: begin
				if (out_free) begin
					ocw_q <= nw;
					osq_q <= quant_q;
					otw_q <= tgt;
				end
			end
			default: ;
		endcase
		if (div_done) begin
			case (div_sel_q)
				DIV_BDP: begin
					whole_q <= div_quo[25:0];
					frac_q  <= div_rem;
				end
				DIV_FRAC: q3_q <= div_quo[31:0];
				default: ;
			endcase
		end
	end

	assign stat.div_busy = div_busy;
	assign stat.div_done = div_done;
	assign stat.out_free = out_free;

	assign out_valid = ov_q;
	assign out_data  = {7'd0, otw_q, osq_q, ocw_q};
endmodule

[rtl/bbr_cwu_ctrl.sv]
`timescale 1ns / 1ps
module bbr_cwu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bbr_cwu_pkg::stat_t stat,
	output bbr_cwu_pkg::cmd_t  cmd
);
	import bbr_cwu_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_RLO   = 14'b00000000000010,
		S_RHI   = 14'b00000000000100,
		S_QDIV  = 14'b00000000001000,
		S_QWAIT = 14'b00000000010000,
		S_BDIV  = 14'b00000000100000,
		S_BWAIT = 14'b00000001000000,
		S_WMUL  = 14'b00000010000000,
		S_FMUL  = 14'b00000100000000,
		S_FDIV  = 14'b00001000000000,
		S_FWAIT = 14'b00010000000000,
		S_BMUL  = 14'b00100000000000,
		S_IMUL  = 14'b01000000000000,
		S_FIN   = 14'b10000000000000
	} state_t;

	state_t st_q, st_n;

	always_comb begin
		st_n          = st_q;
		cmd.op        = OP_NONE;
		cmd.div_start = 1'b0;
		cmd.div_sel   = DIV_QUANTUM;
		in_ready      = 1'b0;
		case (st_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					st_n   = S_RLO;
				end
			end
			S_RLO: begin
				cmd.op = OP_RATE_LO;
				st_n   = S_RHI;
			end
			S_RHI: begin
				cmd.op = OP_RATE_HI;
				st_n   = S_QDIV;
			end
			S_QDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_QUANTUM;
				st_n          = S_QWAIT;
			end
			S_QWAIT: if (stat.div_done) st_n = S_BDIV;
			S_BDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_BDP;
				st_n          = S_BWAIT;
			end
			S_BWAIT: if (stat.div_done) st_n = S_WMUL;
			S_WMUL: begin
				cmd.op = OP_WHOLE_MUL;
				st_n   = S_FMUL;
			end
			S_FMUL: begin
				cmd.op = OP_FRAC_MUL;
				st_n   = S_FDIV;
			end
			S_FDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_FRAC;
				st_n          = S_FWAIT;
			end
			S_FWAIT: if (stat.div_done) st_n = S_BMUL;
			S_BMUL: begin
				cmd.op = OP_BDP_MUL;
				st_n   = S_IMUL;
			end
			S_IMUL: begin
				cmd.op = OP_INIT_MUL;
				st_n   = S_FIN;
			end
			S_FIN: begin
				// wait for room in the output register
				cmd.op = OP_FINISH;
				if (stat.out_free) st_n = S_IDLE;
			end
			default: st_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= S_IDLE;
		else
			st_q <= st_n;
	end
endmodule

[rtl/bbr_congestion_window_update.sv]
// a new request is accepted only once the previous result is in the output register
// the shared constant divider is run three times a request: quantum, BDP and fraction
// an output register holds the result so the next request can start while it waits
// asynchronous active-low reset: gains 512 and 256, initial window 12000,
// congestion window 12000, send quantum 0, no result pending
`timescale 1ns / 1ps
module bbr_congestion_window_update (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// bandwidth, payload_length, total_acked, acked_now, min_rtt_us,
	// min_rtt_valid, bottleneck_found, ack_height, ack_height_valid
	input  logic [bbr_cwu_pkg::IN_W-1:0]  s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// congestion_window, send_quantum, target_window
	output logic [bbr_cwu_pkg::OUT_W-1:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import bbr_cwu_pkg::*;

	`include "bbr_congestion_window_update_assert.svh"

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	bbr_cwu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bbr_cwu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_axis_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	`BBR_ASSERT_NEXT(a_busy_after_request, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`BBR_ASSERT_NOW(a_div_idle_when_ready, s_axis_tready, !stat.div_busy && !stat.div_done)
	`BBR_ASSERT_NOW(a_load_only_when_ready, cmd.op == OP_LOAD, s_axis_tready)
endmodule
